[rtl/swog_pkg.sv]
// shared types, constants and helpers for the sliding window outlier gate
package swog_pkg;

    localparam int WINDOW_MAX_DEF   = 16;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;

    localparam logic [30:0] ABS_THRESHOLD_RST = 31'h7FFF_FFFF;
    localparam logic [15:0] OUTLIER_GAIN_RST  = 16'd512;
    localparam logic [4:0]  WINDOW_LEN_RST    = 5'd16;
    localparam logic [31:0] FACTOR_ONE        = 32'd256;
    localparam int          SQ_SHIFT          = 15;
    localparam int          GAIN_SHIFT        = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ABS_THRESHOLD = 3'd0,
        REG_OUTLIER_GAIN  = 3'd1,
        REG_MIN_BAND      = 3'd2,
        REG_WINDOW_LEN    = 3'd3,
        REG_ADAPTIVE_MODE = 3'd4,
        REG_UPPER_ONLY    = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RDOLD,
        ST_SUBOLD,
        ST_ADD,
        ST_ADD2,
        ST_DIV,
        ST_MSQ,
        ST_VAR,
        ST_ROOT,
        ST_BAND,
        ST_BAND2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

[rtl/sliding_window_outlier_gate_core.sv]
// top level of the sliding window outlier gate
// Takes one signed Q16.16 sample at a time and answers with one result word per sample.
// A rejected sample goes from the check step straight to the output step. An accepted
// sample is written to the window, after the oldest sample is read and dropped when the
// window is full, and its result word follows the mean, square root and band steps.
// The next sample is taken once the core is back in its idle step.
// The window store sits in a ram with one read and one write port and is read and
// written. The running sums are then divided by the fill count in two bit-serial
// dividers running side by side. After that the square root unit runs while, in
// adaptive mode, the gain power is formed, one multiply per cycle.
// A stalled result holds the core in its output step. The output register lets the
// next sample be taken while a result waits.
module sliding_window_outlier_gate_core #(
    parameter int WINDOW_MAX   = swog_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swog_pkg::SAMPLE_WIDTH_DEF,
    parameter int CNT_W        = $clog2(WINDOW_MAX + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic signed [31:0]                  window_mean,
    output logic [30:0]                         band_half_width,
    output logic [CNT_W-1:0]                    fill_count,
    input  logic                                cfg_we,
    input  logic [swog_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swog_pkg::CFG_W-1:0]          cfg_data
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = 32 + CNT_W;
    localparam int SQ_W  = 49 + CNT_W;
    localparam int SX    = 32 - SAMPLE_WIDTH;

    // configuration
    logic [30:0] abs_threshold_reg;
    logic [15:0] outlier_gain_reg;
    logic [30:0] min_band_reg;
    logic [4:0]  window_len_reg;
    logic        adaptive_mode_reg;
    logic        upper_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_threshold_reg <= swog_pkg::ABS_THRESHOLD_RST;
            outlier_gain_reg  <= swog_pkg::OUTLIER_GAIN_RST;
            min_band_reg      <= '0;
            window_len_reg    <= swog_pkg::WINDOW_LEN_RST;
            adaptive_mode_reg <= 1'b0;
            upper_only_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (swog_pkg::cfg_reg_t'(cfg_index))
                swog_pkg::REG_ABS_THRESHOLD: abs_threshold_reg <= cfg_data[30:0];
                swog_pkg::REG_OUTLIER_GAIN:  outlier_gain_reg  <= cfg_data[15:0];
                swog_pkg::REG_MIN_BAND:      min_band_reg      <= cfg_data[30:0];
                swog_pkg::REG_WINDOW_LEN:    window_len_reg    <= cfg_data[4:0];
                swog_pkg::REG_ADAPTIVE_MODE: adaptive_mode_reg <= cfg_data[0];
                swog_pkg::REG_UPPER_ONLY:    upper_only_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state
    swog_pkg::state_t         state_reg, state_next;
    logic signed [31:0]       s_reg, s_next;
    logic signed [31:0]       old_reg, old_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         oldest_reg, oldest_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic signed [31:0]       mean_reg, mean_next;
    logic [30:0]              band_reg, band_next;
    logic [63:0]              prod_reg, prod_next;
    logic [63:0]              ex2_reg, ex2_next;
    logic [31:0]              factor_reg, factor_next;
    logic [CNT_W:0]           pcnt_reg, pcnt_next;
    logic                     acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_acc_reg, out_acc_next;
    logic signed [31:0]       out_mean_reg, out_mean_next;
    logic [30:0]              out_band_reg, out_band_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;

    // ram
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [SAMPLE_WIDTH-1:0]  ram_rdata;
    logic signed [31:0]       ram_sample;
    logic [CNT_W:0]           wpos;

    swog_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_reg[SAMPLE_WIDTH-1:0]),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    assign ram_sample = $signed({ram_rdata, {SX{1'b0}}}) >>> SX;
    assign wpos       = {1'b0, count_reg} + (CNT_W + 1)'(oldest_reg);
    assign ram_waddr  = (wpos >= (CNT_W + 1)'(WINDOW_MAX))
                        ? IDX_W'(wpos - (CNT_W + 1)'(WINDOW_MAX)) : IDX_W'(wpos);

    // dividers
    swog_pkg::unit_ctl_t div_ctl, divm_stat, divq_stat;
    logic [SQ_W-1:0]     sum_mag, mean_quo, sq_quo;

    assign sum_mag = SQ_W'(sum_reg[SUM_W-1] ? -sum_reg : sum_reg);

    swog_div #(.N (SQ_W), .D (CNT_W)) u_div_mean (
        .clk (clk), .rst_n (rst_n), .ctl_in (div_ctl), .ctl_out (divm_stat),
        .dividend (sum_mag), .divisor (count_reg), .quotient (mean_quo)
    );

    swog_div #(.N (SQ_W), .D (CNT_W)) u_div_sq (
        .clk (clk), .rst_n (rst_n), .ctl_in (div_ctl), .ctl_out (divq_stat),
        .dividend (sq_reg), .divisor (count_reg), .quotient (sq_quo)
    );

    // square root
    swog_pkg::unit_ctl_t sqrt_ctl, sqrt_stat;
    logic [63:0]         var_val;
    logic [31:0]         stdev;

    assign var_val = (ex2_reg > prod_reg) ? ex2_reg - prod_reg : '0;

    swog_sqrt u_sqrt (
        .clk (clk), .rst_n (rst_n), .ctl_in (sqrt_ctl), .ctl_out (sqrt_stat),
        .radicand (var_val), .root (stdev)
    );

    // control
    logic [CNT_W-1:0]     len_eff;
    logic signed [32:0]   s_wide, thr_wide;
    logic signed [33:0]   upper, lower, s_cmp;
    logic                 in_band;
    logic [31:0]          mul_a, mul_b;
    logic [47:0]          gain_prod;
    logic [39:0]          gain_shift;
    logic [55:0]          band_shift;
    logic [30:0]          band_sat;
    logic [CNT_W:0]       len_p1;
    logic signed [SQ_W:0] mean_signed;

    always_comb
    begin
        if (window_len_reg < 5'd2)
        begin
            len_eff = CNT_W'(2);
        end
        else if (32'(window_len_reg) > 32'(WINDOW_MAX))
        begin
            len_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = CNT_W'(window_len_reg);
        end
    end

    assign s_wide   = 33'(s_reg);
    assign thr_wide = $signed({2'b00, abs_threshold_reg});
    assign s_cmp    = 34'(s_reg);
    assign upper    = 34'(mean_reg) + $signed({3'b000, band_reg});
    assign lower    = upper_only_reg ? '0 : 34'(mean_reg) - $signed({3'b000, band_reg});
    assign in_band  = ({1'b0, swog_pkg::mag32(s_reg)} <= {2'b00, abs_threshold_reg})
                      && (s_cmp >= lower) && (s_cmp <= upper);

    assign gain_prod  = factor_reg * outlier_gain_reg;
    assign gain_shift = gain_prod[47:swog_pkg::GAIN_SHIFT];
    assign band_shift = prod_reg[63:swog_pkg::GAIN_SHIFT];
    assign band_sat   = (band_shift > 56'h7FFF_FFFF) ? 31'h7FFF_FFFF : band_shift[30:0];
    assign len_p1     = {1'b0, len_eff} + 1'b1;
    assign mean_signed = sum_reg[SUM_W-1] ? -$signed({1'b0, mean_quo})
                                           : $signed({1'b0, mean_quo});

    always_comb
    begin
        unique case (state_reg)
            swog_pkg::ST_RDOLD: mul_a = swog_pkg::mag32(ram_sample);
            swog_pkg::ST_ADD:   mul_a = swog_pkg::mag32(s_reg);
            swog_pkg::ST_VAR:   mul_a = swog_pkg::mag32(mean_reg);
            default:            mul_a = stdev;
        endcase
        mul_b = (state_reg == swog_pkg::ST_BAND) ? factor_reg : mul_a;
    end

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        old_next       = old_reg;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        mean_next      = mean_reg;
        band_next      = band_reg;
        prod_next      = prod_reg;
        ex2_next       = ex2_reg;
        factor_next    = factor_reg;
        pcnt_next      = pcnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_acc_next   = out_acc_reg;
        out_mean_next  = out_mean_reg;
        out_band_next  = out_band_reg;
        out_count_next = out_count_reg;
        ram_we         = 1'b0;
        div_ctl        = '0;
        sqrt_ctl       = '0;
        in_stall       = (state_reg != swog_pkg::ST_IDLE);

        if (pcnt_reg != '0)
        begin
            factor_next = (gain_shift > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : gain_shift[31:0];
            pcnt_next   = pcnt_reg - 1'b1;
        end

        unique case (state_reg)
            swog_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    s_next     = $signed({sample[SAMPLE_WIDTH-1:0], {SX{1'b0}}}) >>> SX;
                    state_next = swog_pkg::ST_CHECK;
                end
            end
            swog_pkg::ST_CHECK:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    acc_next = (s_wide < thr_wide);
                end
                else
                begin
                    acc_next = in_band;
                end
                if (count_reg < CNT_W'(2) ? (s_wide < thr_wide) : in_band)
                begin
                    state_next = (count_reg >= len_eff) ? swog_pkg::ST_RDOLD
                                                        : swog_pkg::ST_ADD;
                end
                else
                begin
                    if (count_reg >= CNT_W'(2))
                    begin
                        count_next  = '0;
                        oldest_next = '0;
                        sum_next    = '0;
                        sq_next     = '0;
                        mean_next   = '0;
                        band_next   = '0;
                    end
                    state_next = swog_pkg::ST_OUT;
                end
            end
            swog_pkg::ST_RDOLD:
            begin
                old_next   = ram_sample;
                prod_next  = mul_a * mul_b;
                state_next = swog_pkg::ST_SUBOLD;
            end
            swog_pkg::ST_SUBOLD:
            begin
                sum_next    = sum_reg - SUM_W'(old_reg);
                sq_next     = sq_reg - SQ_W'(prod_reg >> swog_pkg::SQ_SHIFT);
                oldest_next = (32'(oldest_reg) == WINDOW_MAX - 1) ? '0
                              : oldest_reg + 1'b1;
                count_next  = count_reg - 1'b1;
                state_next  = swog_pkg::ST_ADD;
            end
            swog_pkg::ST_ADD:
            begin
                ram_we     = 1'b1;
                prod_next  = mul_a * mul_b;
                state_next = swog_pkg::ST_ADD2;
            end
            swog_pkg::ST_ADD2:
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(s_reg);
                sq_next    = sq_reg + SQ_W'(prod_reg >> swog_pkg::SQ_SHIFT);
                state_next = swog_pkg::ST_DIV;
            end
            swog_pkg::ST_DIV:
            begin
                div_ctl.start = 1'b1;
                state_next    = swog_pkg::ST_MSQ;
            end
            swog_pkg::ST_MSQ:
            begin
                if (!divm_stat.busy && !divq_stat.busy)
                begin
                    mean_next  = 32'(mean_signed);
                    ex2_next   = 64'(sq_quo) << swog_pkg::SQ_SHIFT;
                    state_next = swog_pkg::ST_VAR;
                end
            end
            swog_pkg::ST_VAR:
            begin
                prod_next = mul_a * mul_b;
                if (adaptive_mode_reg)
                begin
                    factor_next = swog_pkg::FACTOR_ONE;
                    pcnt_next   = (len_p1 > {1'b0, count_reg})
                                  ? len_p1 - {1'b0, count_reg} : '0;
                end
                else
                begin
                    factor_next = 32'(outlier_gain_reg);
                    pcnt_next   = '0;
                end
                state_next = swog_pkg::ST_ROOT;
            end
            swog_pkg::ST_ROOT:
            begin
                sqrt_ctl.start = 1'b1;
                state_next     = swog_pkg::ST_BAND;
            end
            swog_pkg::ST_BAND:
            begin
                if (!sqrt_stat.busy && pcnt_reg == '0)
                begin
                    prod_next  = mul_a * mul_b;
                    state_next = swog_pkg::ST_BAND2;
                end
            end
            swog_pkg::ST_BAND2:
            begin
                band_next  = (band_sat < min_band_reg) ? min_band_reg : band_sat;
                state_next = swog_pkg::ST_OUT;
            end
            swog_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_mean_next  = mean_reg;
                    out_band_next  = band_reg;
                    out_count_next = count_reg;
                    state_next     = swog_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swog_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swog_pkg::ST_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            mean_reg      <= '0;
            band_reg      <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            mean_reg      <= mean_next;
            band_reg      <= band_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        old_reg       <= old_next;
        prod_reg      <= prod_next;
        ex2_reg       <= ex2_next;
        factor_reg    <= factor_next;
        acc_reg       <= acc_next;
        out_acc_reg   <= out_acc_next;
        out_mean_reg  <= out_mean_next;
        out_band_reg  <= out_band_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid       = out_valid_reg;
    assign accepted        = out_acc_reg;
    assign window_mean     = out_mean_reg;
    assign band_half_width = out_band_reg;
    assign fill_count      = out_count_reg;

endmodule

[rtl/swog_ram.sv]
// generic single write port ram with registered read
module swog_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/swog_div.sv]
// unsigned restoring divider, one quotient bit per cycle
module swog_div #(
    parameter int N = 52,
    parameter int D = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  swog_pkg::unit_ctl_t      ctl_in,
    output swog_pkg::unit_ctl_t      ctl_out,
    input  logic [N-1:0]             dividend,
    input  logic [D-1:0]             divisor,
    output logic [N-1:0]             quotient
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg, quo_next;
    logic [D:0]    rem_reg, rem_next;
    logic [D-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [D:0]    trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg[D-1:0], quo_reg[N-1]};
        if (ctl_in.start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(N);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient      = quo_reg;
    assign ctl_out.start = 1'b0;
    assign ctl_out.busy  = (cnt_reg != '0);

endmodule

[rtl/swog_sqrt.sv]
// integer square root of a 64 bit value, one result bit per cycle
module swog_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  swog_pkg::unit_ctl_t ctl_in,
    output swog_pkg::unit_ctl_t ctl_out,
    input  logic [63:0]         radicand,
    output logic [31:0]         root
);

    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    always_comb
    begin
        v_next   = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        trial    = res_reg + bit_reg;
        if (ctl_in.start)
        begin
            v_next   = radicand;
            res_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
        end
        else if (bit_reg != '0)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign root          = res_reg[31:0];
    assign ctl_out.start = 1'b0;
    assign ctl_out.busy  = (bit_reg != '0);

endmodule
